// ----- design/rtbu_pkg.sv -----
// Shared types and constants for the route table batch update block.
// No dependencies; every other file imports this package.
`default_nettype none

package rtbu_pkg;

	localparam int FIELD_W     = 16;
	localparam int BATCH_DEPTH = 16;
	localparam int TABLE_DEPTH = 64;

	localparam int BATCH_AW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
	localparam int BATCH_CW = $clog2(BATCH_DEPTH + 1);
	localparam int TABLE_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TABLE_CW = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		logic [FIELD_W-1:0] metric;
		logic [FIELD_W-1:0] target;
		logic [FIELD_W-1:0] next_hop;
		logic [FIELD_W-1:0] origin;
	} route_entry_t;

	typedef struct packed {
		logic         has_entry;
		route_entry_t route;
		logic         any_changed;
		logic         table_full;
		logic         delta_last;
	} delta_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MERGE,
		ST_MUPD,
		ST_BRD,
		ST_BLATCH,
		ST_TSCAN,
		ST_TUPD,
		ST_ORD,
		ST_OLOAD,
		ST_OWAIT
	} ctrl_state_t;

	typedef struct packed {
		logic load_offer;
		logic merge_scan;
		logic merge_write;
		logic batch_read;
		logic entry_latch;
		logic table_scan;
		logic table_update;
		logic out_empty;
		logic out_read;
		logic out_load;
		logic out_next;
		logic batch_clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic merge_done;
		logic scan_done;
		logic offer_end;
		logic last_entry;
		logic nchg_zero;
		logic out_last;
	} ctrl_stat_t;

endpackage

`default_nettype wire

// ----- design/rtbu_offer_if.sv -----
// Input channel carrying one route offer per transfer.
// Depends on rtbu_pkg for the field width.
`default_nettype none

interface rtbu_offer_if import rtbu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] origin_node;
	logic [FIELD_W-1:0] next_hop;
	logic [FIELD_W-1:0] target_node;
	logic [FIELD_W-1:0] route_metric;
	logic               batch_end;

	modport source (
		output valid, origin_node, next_hop, target_node, route_metric, batch_end,
		input  ready
	);
	modport sink (
		input  valid, origin_node, next_hop, target_node, route_metric, batch_end,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/rtbu_delta_if.sv -----
// Output channel carrying one delta result per transfer.
// Depends on rtbu_pkg for the field width.
`default_nettype none

interface rtbu_delta_if import rtbu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               has_entry;
	logic [FIELD_W-1:0] out_origin;
	logic [FIELD_W-1:0] out_next_hop;
	logic [FIELD_W-1:0] out_target;
	logic [FIELD_W-1:0] out_metric;
	logic               any_changed;
	logic               table_full;
	logic               delta_last;

	modport source (
		output valid, has_entry, out_origin, out_next_hop, out_target, out_metric,
		output any_changed, table_full, delta_last,
		input  ready
	);
	modport sink (
		input  valid, has_entry, out_origin, out_next_hop, out_target, out_metric,
		input  any_changed, table_full, delta_last,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/rtbu_dpath.sv -----
// Datapath: batch store, route table, scan counters, change list, output register.
// Depends on rtbu_pkg; driven by commands from rtbu_ctrl.
`default_nettype none

module rtbu_dpath import rtbu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  route_entry_t offer_entry,
	input  logic         offer_end,
	input  ctrl_cmd_t    cmd,
	output ctrl_stat_t   stat,
	output delta_t       delta
);

	route_entry_t bmem [BATCH_DEPTH];
	route_entry_t rmem [TABLE_DEPTH];
	logic [BATCH_AW-1:0] clist_q [BATCH_DEPTH];

	route_entry_t off_q;
	route_entry_t cur_q;
	route_entry_t brd_s1;
	route_entry_t rrd_s1;
	delta_t       delta_q;
	logic         end_q;

	logic [BATCH_CW-1:0] bcnt_q;
	logic [BATCH_CW-1:0] j_q;
	logic [BATCH_CW-1:0] nchg_q;
	logic [BATCH_AW-1:0] bi_q;
	logic [BATCH_AW-1:0] oi_q;
	logic [BATCH_AW-1:0] jidx_s1;
	logic [BATCH_AW-1:0] found_idx_q;
	logic [FIELD_W-1:0]  found_met_q;
	logic                bpend_s1;
	logic                found_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_CW-1:0]    k_q;
	logic [TABLE_AW-1:0]    kidx_s1;
	logic [TABLE_AW-1:0]    hit_idx_q;
	logic [TABLE_AW-1:0]    free_idx_q;
	logic                   rpend_s1;
	logic                   hit_q;
	logic                   hit_eq_q;
	logic                   free_q;
	logic                   full_q;

	logic                b_issue;
	logic                b_ren;
	logic [BATCH_AW-1:0] b_raddr;
	logic                b_hit;
	logic                bwr_en;
	logic [BATCH_AW-1:0] bwr_addr;
	logic                r_issue;
	logic                r_hit;
	logic                r_free;
	logic                rwr_en;
	logic [TABLE_AW-1:0] rwr_addr;

	assign b_issue = cmd.merge_scan && (j_q != bcnt_q);
	assign r_issue = cmd.table_scan && (k_q != TABLE_CW'(TABLE_DEPTH));
	assign b_ren   = b_issue | cmd.batch_read | cmd.out_read;

	always_comb begin
		priority if (b_issue) begin
			b_raddr = j_q[BATCH_AW-1:0];
		end else if (cmd.batch_read) begin
			b_raddr = bi_q;
		end else begin
			b_raddr = clist_q[oi_q];
		end
	end

	assign b_hit  = bpend_s1 && !found_q && (brd_s1.target == off_q.target);
	assign r_hit  = rpend_s1 && !hit_q && valid_q[kidx_s1] && (rrd_s1.target == cur_q.target);
	assign r_free = rpend_s1 && !free_q && !valid_q[kidx_s1];

	// Merge: overwrite a kept offer only on a strictly lower metric.
	always_comb begin
		bwr_en   = 1'b0;
		bwr_addr = found_idx_q;
		if (cmd.merge_write) begin
			if (found_q) begin
				bwr_en = (off_q.metric < found_met_q);
			end else if (bcnt_q != BATCH_CW'(BATCH_DEPTH)) begin
				bwr_en   = 1'b1;
				bwr_addr = bcnt_q[BATCH_AW-1:0];
			end
		end
	end

	always_comb begin
		rwr_en   = 1'b0;
		rwr_addr = hit_idx_q;
		if (cmd.table_update) begin
			if (hit_q) begin
				rwr_en = !hit_eq_q;
			end else if (free_q) begin
				rwr_en   = 1'b1;
				rwr_addr = free_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bwr_en) begin
			bmem[bwr_addr] <= off_q;
		end
		if (b_ren) begin
			brd_s1 <= bmem[b_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (rwr_en) begin
			rmem[rwr_addr] <= cur_q;
		end
		if (r_issue) begin
			rrd_s1 <= rmem[k_q[TABLE_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q   <= '0;
			j_q      <= '0;
			nchg_q   <= '0;
			bi_q     <= '0;
			oi_q     <= '0;
			bpend_s1 <= 1'b0;
			found_q  <= 1'b0;
			valid_q  <= '0;
			k_q      <= '0;
			rpend_s1 <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			full_q   <= 1'b0;
		end else begin
			bpend_s1 <= b_issue;
			rpend_s1 <= r_issue;
			if (cmd.load_offer) begin
				j_q     <= '0;
				found_q <= 1'b0;
			end
			if (b_issue) begin
				j_q <= j_q + 1'b1;
			end
			if (b_hit) begin
				found_q <= 1'b1;
			end
			if (cmd.merge_write && !found_q && (bcnt_q != BATCH_CW'(BATCH_DEPTH))) begin
				bcnt_q <= bcnt_q + 1'b1;
			end
			if (cmd.entry_latch) begin
				k_q    <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			if (r_issue) begin
				k_q <= k_q + 1'b1;
			end
			if (r_hit) begin
				hit_q <= 1'b1;
			end
			if (r_free) begin
				free_q <= 1'b1;
			end
			if (cmd.table_update) begin
				bi_q <= bi_q + 1'b1;
				if (rwr_en) begin
					nchg_q <= nchg_q + 1'b1;
				end
				if (!hit_q && free_q) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (!hit_q && !free_q) begin
					full_q <= 1'b1;
				end
			end
			if (cmd.out_next) begin
				oi_q <= oi_q + 1'b1;
			end
			if (cmd.batch_clear) begin
				bcnt_q <= '0;
				bi_q   <= '0;
				oi_q   <= '0;
				nchg_q <= '0;
				full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		jidx_s1 <= j_q[BATCH_AW-1:0];
		kidx_s1 <= k_q[TABLE_AW-1:0];
		if (cmd.load_offer) begin
			off_q <= offer_entry;
			end_q <= offer_end;
		end
		if (b_hit) begin
			found_idx_q <= jidx_s1;
			found_met_q <= brd_s1.metric;
		end
		if (cmd.entry_latch) begin
			cur_q <= brd_s1;
		end
		if (r_hit) begin
			hit_idx_q <= kidx_s1;
			hit_eq_q  <= (rrd_s1 == cur_q);
		end
		if (r_free) begin
			free_idx_q <= kidx_s1;
		end
		if (rwr_en) begin
			clist_q[nchg_q[BATCH_AW-1:0]] <= bi_q;
		end
		if (cmd.out_empty) begin
			delta_q.has_entry   <= 1'b0;
			delta_q.route       <= '0;
			delta_q.any_changed <= 1'b0;
			delta_q.table_full  <= full_q;
			delta_q.delta_last  <= 1'b1;
		end else if (cmd.out_load) begin
			delta_q.has_entry   <= 1'b1;
			delta_q.route       <= brd_s1;
			delta_q.any_changed <= 1'b1;
			delta_q.table_full  <= full_q;
			delta_q.delta_last  <= ((BATCH_CW'(oi_q) + 1'b1) == nchg_q);
		end
	end

	assign stat.merge_done = (j_q == bcnt_q) && !bpend_s1;
	assign stat.scan_done  = (k_q == TABLE_CW'(TABLE_DEPTH)) && !rpend_s1;
	assign stat.offer_end  = end_q;
	assign stat.last_entry = ((BATCH_CW'(bi_q) + 1'b1) == bcnt_q);
	assign stat.nchg_zero  = (nchg_q == '0);
	assign stat.out_last   = delta_q.delta_last;

	assign delta = delta_q;

endmodule

`default_nettype wire

// ----- design/rtbu_ctrl.sv -----
// Controller state machine: sequences merge, table scan and delta output.
// Depends on rtbu_pkg; drives rtbu_dpath through command and status structs.
`default_nettype none

module rtbu_ctrl import rtbu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_MERGE;
			end
			ST_MERGE: begin
				if (stat.merge_done) state_nxt = ST_MUPD;
			end
			ST_MUPD: begin
				state_nxt = stat.offer_end ? ST_BRD : ST_IDLE;
			end
			ST_BRD:    state_nxt = ST_BLATCH;
			ST_BLATCH: state_nxt = ST_TSCAN;
			ST_TSCAN: begin
				if (stat.scan_done) state_nxt = ST_TUPD;
			end
			ST_TUPD: begin
				state_nxt = stat.last_entry ? ST_ORD : ST_BRD;
			end
			ST_ORD: begin
				state_nxt = stat.nchg_zero ? ST_OWAIT : ST_OLOAD;
			end
			ST_OLOAD: state_nxt = ST_OWAIT;
			ST_OWAIT: begin
				if (out_ready) state_nxt = stat.out_last ? ST_IDLE : ST_ORD;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.load_offer = in_valid;
			end
			ST_MERGE:  cmd.merge_scan   = 1'b1;
			ST_MUPD:   cmd.merge_write  = 1'b1;
			ST_BRD:    cmd.batch_read   = 1'b1;
			ST_BLATCH: cmd.entry_latch  = 1'b1;
			ST_TSCAN:  cmd.table_scan   = 1'b1;
			ST_TUPD:   cmd.table_update = 1'b1;
			ST_ORD: begin
				cmd.out_empty = stat.nchg_zero;
				cmd.out_read  = !stat.nchg_zero;
			end
			ST_OLOAD:  cmd.out_load     = 1'b1;
			ST_OWAIT: begin
				out_valid       = 1'b1;
				cmd.batch_clear = out_ready && stat.out_last;
				cmd.out_next    = out_ready && !stat.out_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/route_table_batch_update_core.sv -----
// Top level of the route table batch update block.
// Depends on rtbu_pkg, rtbu_offer_if, rtbu_delta_if, rtbu_ctrl and rtbu_dpath.
//
// Usage:
//   offer : sink channel, one route offer per transfer (origin, next hop,
//           target, metric, batch_end). Offers gather into a batch; within
//           the batch the lowest metric per target is kept, first on a tie.
//   delta : source channel. After the offer that carries batch_end, each kept
//           offer that is new to the table (if a slot is free) or differs from
//           it is written in and sent, in order of first appearance of its
//           target. With no change a single empty result is sent. table_full
//           is the same on every result of a batch; delta_last marks the last.
// Sequencing, with the kept offers of the open batch:
//   an offer without batch_end holds the block while every kept offer is
//   compared with it (scan of the batch store through its single registered
//   read port);
//   an offer with batch_end then scans the whole table once per kept offer,
//   bound by the table memory read port; each changed result is then read
//   from the batch store into the output register, and may be held by a receiver stall.
//   Offers are taken one at a time; ready is low while a batch is resolved
//   or its results are out.
// Receiver stall: the result sits in the output register and holds until
//   transferred; nothing is dropped.
// Reset: table and batch are empty at once; no clearing pass is needed.
`default_nettype none

module route_table_batch_update_core import rtbu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rtbu_offer_if.sink   offer,
	rtbu_delta_if.source delta
);

	ctrl_cmd_t    cmd;
	ctrl_stat_t   stat;
	route_entry_t offer_entry;
	delta_t       delta_res;

	// Pack the offer fields into a table entry.
	assign offer_entry.origin   = offer.origin_node;
	assign offer_entry.next_hop = offer.next_hop;
	assign offer_entry.target   = offer.target_node;
	assign offer_entry.metric   = offer.route_metric;

	rtbu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (offer.valid),
		.in_ready  (offer.ready),
		.out_valid (delta.valid),
		.out_ready (delta.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rtbu_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.offer_entry (offer_entry),
		.offer_end   (offer.batch_end),
		.cmd         (cmd),
		.stat        (stat),
		.delta       (delta_res)
	);

	// Unpack the output register onto the result channel.
	assign delta.has_entry    = delta_res.has_entry;
	assign delta.out_origin   = delta_res.route.origin;
	assign delta.out_next_hop = delta_res.route.next_hop;
	assign delta.out_target   = delta_res.route.target;
	assign delta.out_metric   = delta_res.route.metric;
	assign delta.any_changed  = delta_res.any_changed;
	assign delta.table_full   = delta_res.table_full;
	assign delta.delta_last   = delta_res.delta_last;

endmodule

`default_nettype wire
